// ----- design/mlvm_pkg.sv -----
package mlvm_pkg;

	typedef struct packed {
		logic signed [15:0] delta_x;
		logic signed [15:0] delta_y;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] right_x;
		logic signed [15:0] right_y;
		logic signed [15:0] right_z;
		logic signed [15:0] up_x;
		logic signed [15:0] up_y;
		logic signed [15:0] up_z;
		logic signed [15:0] back_x;
		logic signed [15:0] back_y;
		logic signed [15:0] back_z;
		logic signed [31:0] shift_x;
		logic signed [31:0] shift_y;
		logic signed [31:0] shift_z;
	} out_item_t;

	typedef enum logic [1:0] {
		CFG_LOOK_SPEED = 2'd0,
		CFG_POSITION_X = 2'd1,
		CFG_POSITION_Y = 2'd2,
		CFG_POSITION_Z = 2'd3
	} cfg_index_t;

	typedef enum logic [2:0] {
		F_IDLE,
		F_MULX,
		F_MULY,
		F_WRAP,
		F_PUSH
	} front_state_t;

	typedef enum logic [3:0] {
		B_IDLE,
		B_RED,
		B_XM,
		B_X2M,
		B_X2,
		B_H1,
		B_H2,
		B_H3,
		B_SM,
		B_SC,
		B_PM,
		B_PS,
		B_DM,
		B_DA,
		B_OUT
	} back_state_t;

	// Q30 fixed point
	localparam logic signed [31:0] Q30_ONE = 32'sd1073741824;
	// pi/180 in Q30
	localparam logic [24:0] DEG_TO_RAD = 25'd18740330;

	// Horner divisors and floor(2^30 / d)
	localparam logic [6:0]  SIN_DIV   [0:4] = '{7'd110, 7'd72, 7'd42, 7'd20, 7'd6};
	localparam logic [6:0]  COS_DIV   [0:4] = '{7'd90, 7'd56, 7'd30, 7'd12, 7'd2};
	localparam logic [29:0] SIN_RECIP [0:4] = '{30'd9761289, 30'd14913080, 30'd25565281,
		30'd53687091, 30'd178956970};
	localparam logic [29:0] COS_RECIP [0:4] = '{30'd11930464, 30'd19173961, 30'd35791394,
		30'd89478485, 30'd536870912};

endpackage

// ----- design/mlvm_queue.sv -----
module mlvm_queue #(
	parameter int W = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] pop_data,
	output logic         empty
);

	logic [W-1:0] mem_q [2];
	logic         wr_q;
	logic         rd_q;
	logic [1:0]   cnt_q;

	assign full     = (cnt_q == 2'd2);
	assign empty    = (cnt_q == 2'd0);
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push && !full) begin
				wr_q <= ~wr_q;
			end
			if (pop && !empty) begin
				rd_q <= ~rd_q;
			end
			case ({push && !full, pop && !empty})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ----- design/mlvm_front.sv -----
module mlvm_front #(
	parameter int ANGLE_FRAC_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  mlvm_pkg::in_item_t              in_data,
	input  logic [15:0]                     look_speed,
	input  logic                            q_full,
	output logic                            q_push,
	output logic [2*ANGLE_FRAC_BITS+16:0]   q_data
);
	import mlvm_pkg::*;

	localparam int YAW_W   = ANGLE_FRAC_BITS + 9;
	localparam int PITCH_W = ANGLE_FRAC_BITS + 8;
	localparam int YW      = ANGLE_FRAC_BITS + 13;
	localparam int STEP_SH = 20 - ANGLE_FRAC_BITS;

	localparam logic signed [YW-1:0] D89   = YW'(89 <<< ANGLE_FRAC_BITS);
	localparam logic signed [YW-1:0] D180  = YW'(180 <<< ANGLE_FRAC_BITS);
	localparam logic signed [YW-1:0] D360  = YW'(360 <<< ANGLE_FRAC_BITS);
	localparam logic signed [YW-1:0] D720  = YW'(720 <<< ANGLE_FRAC_BITS);
	localparam logic signed [YW-1:0] D1440 = YW'(1440 <<< ANGLE_FRAC_BITS);
	localparam logic signed [YW-1:0] D2880 = YW'(64'sd2880 <<< ANGLE_FRAC_BITS);

	front_state_t state_q, state_d;

	logic signed [15:0]        dx_q, dy_q;
	logic signed [32:0]        prod_q, mul_d;
	logic signed [15:0]        mul_a;
	logic signed [YW-1:0]      y_q, step, pitch_sum;
	logic signed [PITCH_W-1:0] p_q, p_clamp;
	logic signed [YAW_W-1:0]   yaw_q, yaw_new;
	logic signed [PITCH_W-1:0] pitch_q;
	logic [1:0]                cnt_q;

	assign mul_a   = (state_q == F_MULX) ? dx_q : dy_q;
	assign mul_d   = 33'(mul_a) * $signed({17'b0, look_speed});
	assign step    = YW'(prod_q >>> STEP_SH);
	assign yaw_new = YAW_W'(y_q - D180);

	assign pitch_sum = YW'(pitch_q) + step;
	always_comb begin
		if (pitch_sum > D89) begin
			p_clamp = PITCH_W'(D89);
		end else if (pitch_sum < -D89) begin
			p_clamp = PITCH_W'(-D89);
		end else begin
			p_clamp = PITCH_W'(pitch_sum);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			F_IDLE:  if (in_valid) state_d = F_MULX;
			F_MULX:  state_d = F_MULY;
			F_MULY:  state_d = F_WRAP;
			F_WRAP:  if (cnt_q == 2'd3) state_d = F_PUSH;
			F_PUSH:  if (!q_full) state_d = F_IDLE;
			default: state_d = F_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_stall = 1'b1;
		q_push   = 1'b0;
		case (state_q)
			F_IDLE:  in_stall = 1'b0;
			F_PUSH:  q_push = !q_full;
			default: begin
				in_stall = 1'b1;
				q_push   = 1'b0;
			end
		endcase
	end

	assign q_data = {yaw_new, p_q};

	always_ff @(posedge clk) begin
		prod_q <= mul_d;
		if (state_q == F_IDLE && in_valid) begin
			dx_q <= in_data.delta_x;
			dy_q <= in_data.delta_y;
		end
		if (state_q == F_MULY) begin
			y_q <= YW'(yaw_q) + step + D180;
		end
		if (state_q == F_WRAP) begin
			case (cnt_q)
				2'd0: begin
					p_q <= p_clamp;
					if (y_q < 0) y_q <= y_q + D2880;
				end
				2'd1:    if (y_q >= D1440) y_q <= y_q - D1440;
				2'd2:    if (y_q >= D720) y_q <= y_q - D720;
				default: if (y_q >= D360) y_q <= y_q - D360;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			cnt_q   <= 2'd0;
			yaw_q   <= '0;
			pitch_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == F_WRAP) begin
				cnt_q <= cnt_q + 2'd1;
			end
			if (state_q == F_PUSH && !q_full) begin
				yaw_q   <= yaw_new;
				pitch_q <= p_q;
			end
		end
	end

endmodule

// ----- design/mlvm_back.sv -----
module mlvm_back #(
	parameter int ANGLE_FRAC_BITS = 16,
	parameter int UNIT_FRAC_BITS  = 14
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_empty,
	output logic                          q_pop,
	input  logic [2*ANGLE_FRAC_BITS+16:0] q_data,
	input  logic signed [31:0]            position_x,
	input  logic signed [31:0]            position_y,
	input  logic signed [31:0]            position_z,
	output logic                          out_valid,
	input  logic                          out_stall,
	output mlvm_pkg::out_item_t           out_data
);
	import mlvm_pkg::*;

	localparam int YAW_W   = ANGLE_FRAC_BITS + 9;
	localparam int PITCH_W = ANGLE_FRAC_BITS + 8;
	localparam int R_W     = ANGLE_FRAC_BITS + 7;
	localparam int UNIT_SH = 30 - UNIT_FRAC_BITS;

	localparam logic signed [YAW_W-1:0] D45  = YAW_W'(45 <<< ANGLE_FRAC_BITS);
	localparam logic signed [YAW_W-1:0] D90  = YAW_W'(90 <<< ANGLE_FRAC_BITS);
	localparam logic signed [YAW_W-1:0] D135 = YAW_W'(135 <<< ANGLE_FRAC_BITS);
	localparam logic signed [YAW_W-1:0] D180 = YAW_W'(180 <<< ANGLE_FRAC_BITS);

	localparam logic [1:0] QUAD_0 = 2'd0;
	localparam logic [1:0] QUAD_1 = 2'd1;
	localparam logic [1:0] QUAD_2 = 2'd2;
	localparam logic [1:0] QUAD_3 = 2'd3;

	function automatic logic signed [15:0] unit_out(input logic signed [32:0] v);
		logic signed [33:0] t;
		t = (34'(v) + (34'sd1 <<< (UNIT_SH - 1))) >>> UNIT_SH;
		if (t > 34'sd32767) begin
			return 16'sh7fff;
		end else if (t < -34'sd32768) begin
			return 16'sh8000;
		end
		return 16'(t);
	endfunction

	function automatic logic signed [31:0] shift_out(input logic signed [65:0] s,
		input logic negate);
		logic signed [36:0] t;
		t = 37'((s + 66'sd536870912) >>> 30);
		if (negate) t = -t;
		if (t > 37'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (t < -37'sd2147483648) begin
			return 32'sh80000000;
		end
		return 32'(t);
	endfunction

	back_state_t state_q, state_d;

	logic signed [YAW_W-1:0]   yaw_q, a_ext, red_r;
	logic signed [PITCH_W-1:0] pitch_q;
	logic signed [R_W-1:0]     r_q;
	logic [1:0]                quad_q, red_quad;
	logic                      sel_q, fn_q;
	logic [2:0]                it_q, k_q;
	logic signed [65:0]        prod_q, prod_d, acc_q, dot_sum;
	logic signed [32:0]        mul_a, mul_b;
	logic signed [31:0]        x_q, x2_q, ts_q, tc_q;
	logic signed [31:0]        sy_q, cy_q, sp_q, cp_q, fx_q, fz_q, ux_q, uz_q;
	logic signed [31:0]        shx_q, shy_q, shz_q;
	logic signed [31:0]        s_val, c_val, t_new, prod_q30;
	logic [29:0]               m_q, q0, quo;
	logic [6:0]                div;
	logic [29:0]               recip;
	logic [36:0]               rem;
	logic                      out_load;
	out_item_t                 out_q;
	logic                      out_valid_q;

	// angle reduction to [-45,45) and quadrant
	assign a_ext = sel_q ? YAW_W'(pitch_q) : yaw_q;
	always_comb begin
		if (a_ext < -D135) begin
			red_r = a_ext + D180; red_quad = QUAD_2;
		end else if (a_ext < -D45) begin
			red_r = a_ext + D90;  red_quad = QUAD_3;
		end else if (a_ext < D45) begin
			red_r = a_ext;        red_quad = QUAD_0;
		end else if (a_ext < D135) begin
			red_r = a_ext - D90;  red_quad = QUAD_1;
		end else begin
			red_r = a_ext - D180; red_quad = QUAD_2;
		end
	end

	assign div   = fn_q ? COS_DIV[it_q] : SIN_DIV[it_q];
	assign recip = fn_q ? COS_RECIP[it_q] : SIN_RECIP[it_q];

	// quotient from reciprocal, one correction step
	assign q0    = prod_q[59:30];
	assign rem   = {7'b0, m_q} - (37'(q0) * 37'(div));
	assign quo   = (rem >= 37'(div)) ? q0 + 30'd1 : q0;
	assign t_new = Q30_ONE - $signed({2'b0, quo});

	assign prod_q30 = 32'(prod_q >>> 30);
	assign s_val    = prod_q30;
	assign c_val    = tc_q;
	assign dot_sum  = acc_q + prod_q;

	// shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			B_XM: begin
				mul_a = 33'(r_q);
				mul_b = $signed({8'b0, DEG_TO_RAD});
			end
			B_X2M: begin
				mul_a = 33'(32'(prod_q >>> ANGLE_FRAC_BITS));
				mul_b = 33'(32'(prod_q >>> ANGLE_FRAC_BITS));
			end
			B_H1: begin
				mul_a = 33'(x2_q);
				mul_b = fn_q ? 33'(tc_q) : 33'(ts_q);
			end
			B_H2: begin
				mul_a = $signed({3'b0, prod_q[59:30]});
				mul_b = $signed({3'b0, recip});
			end
			B_SM: begin
				mul_a = 33'(x_q);
				mul_b = 33'(ts_q);
			end
			B_PM: begin
				mul_a = (k_q[1]) ? 33'(sp_q) : 33'(cp_q);
				mul_b = (k_q[0]) ? 33'(sy_q) : 33'(cy_q);
			end
			B_DM: begin
				case (k_q)
					3'd0:    begin mul_a = -33'(sy_q); mul_b = 33'(position_x); end
					3'd1:    begin mul_a = 33'(cy_q);  mul_b = 33'(position_z); end
					3'd2:    begin mul_a = 33'(ux_q);  mul_b = 33'(position_x); end
					3'd3:    begin mul_a = 33'(cp_q);  mul_b = 33'(position_y); end
					3'd4:    begin mul_a = 33'(uz_q);  mul_b = 33'(position_z); end
					3'd5:    begin mul_a = 33'(fx_q);  mul_b = 33'(position_x); end
					3'd6:    begin mul_a = 33'(sp_q);  mul_b = 33'(position_y); end
					default: begin mul_a = 33'(fz_q);  mul_b = 33'(position_z); end
				endcase
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end
	assign prod_d = 66'(mul_a) * 66'(mul_b);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			B_IDLE:  if (!q_empty) state_d = B_RED;
			B_RED:   state_d = B_XM;
			B_XM:    state_d = B_X2M;
			B_X2M:   state_d = B_X2;
			B_X2:    state_d = B_H1;
			B_H1:    state_d = B_H2;
			B_H2:    state_d = B_H3;
			B_H3:    state_d = (fn_q && it_q == 3'd4) ? B_SM : B_H1;
			B_SM:    state_d = B_SC;
			B_SC:    state_d = sel_q ? B_PM : B_RED;
			B_PM:    state_d = B_PS;
			B_PS:    state_d = (k_q == 3'd3) ? B_DM : B_PM;
			B_DM:    state_d = B_DA;
			B_DA:    state_d = (k_q == 3'd7) ? B_OUT : B_DM;
			B_OUT:   if (out_load) state_d = B_IDLE;
			default: state_d = B_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		q_pop    = 1'b0;
		out_load = 1'b0;
		case (state_q)
			B_IDLE:  q_pop = !q_empty;
			B_OUT:   out_load = !out_valid_q || !out_stall;
			default: begin
				q_pop    = 1'b0;
				out_load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= prod_d;
		case (state_q)
			B_IDLE: begin
				yaw_q   <= q_data[2*ANGLE_FRAC_BITS+16 -: YAW_W];
				pitch_q <= q_data[PITCH_W-1:0];
			end
			B_RED: begin
				r_q    <= R_W'(red_r);
				quad_q <= red_quad;
			end
			B_X2M: x_q <= 32'(prod_q >>> ANGLE_FRAC_BITS);
			B_X2: begin
				x2_q <= prod_q30;
				ts_q <= Q30_ONE;
				tc_q <= Q30_ONE;
			end
			B_H2: m_q <= prod_q[59:30];
			B_H3: begin
				if (fn_q) tc_q <= t_new;
				else      ts_q <= t_new;
			end
			B_SC: begin
				case (quad_q)
					QUAD_0: begin
						if (sel_q) begin sp_q <= s_val;  cp_q <= c_val;  end
						else       begin sy_q <= s_val;  cy_q <= c_val;  end
					end
					QUAD_1: begin
						if (sel_q) begin sp_q <= c_val;  cp_q <= -s_val; end
						else       begin sy_q <= c_val;  cy_q <= -s_val; end
					end
					QUAD_2: begin
						if (sel_q) begin sp_q <= -s_val; cp_q <= -c_val; end
						else       begin sy_q <= -s_val; cy_q <= -c_val; end
					end
					default: begin
						if (sel_q) begin sp_q <= -c_val; cp_q <= s_val;  end
						else       begin sy_q <= -c_val; cy_q <= s_val;  end
					end
				endcase
			end
			B_PS: begin
				case (k_q[1:0])
					2'd0:    fx_q <= prod_q30;
					2'd1:    fz_q <= prod_q30;
					2'd2:    ux_q <= -prod_q30;
					default: uz_q <= -prod_q30;
				endcase
			end
			B_DA: begin
				case (k_q)
					3'd1: begin shx_q <= shift_out(dot_sum, 1'b1); acc_q <= '0; end
					3'd4: begin shy_q <= shift_out(dot_sum, 1'b1); acc_q <= '0; end
					3'd7: begin shz_q <= shift_out(dot_sum, 1'b0); acc_q <= '0; end
					default: acc_q <= dot_sum;
				endcase
			end
			B_OUT: begin
				if (out_load) begin
					out_q.right_x <= unit_out(-33'(sy_q));
					out_q.right_y <= '0;
					out_q.right_z <= unit_out(33'(cy_q));
					out_q.up_x    <= unit_out(33'(ux_q));
					out_q.up_y    <= unit_out(33'(cp_q));
					out_q.up_z    <= unit_out(33'(uz_q));
					out_q.back_x  <= unit_out(-33'(fx_q));
					out_q.back_y  <= unit_out(-33'(sp_q));
					out_q.back_z  <= unit_out(-33'(fz_q));
					out_q.shift_x <= shx_q;
					out_q.shift_y <= shy_q;
					out_q.shift_z <= shz_q;
				end
			end
			default: begin
			end
		endcase
		if (state_q == B_PM && k_q == 3'd0) begin
			acc_q <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			sel_q       <= 1'b0;
			fn_q        <= 1'b0;
			it_q        <= 3'd0;
			k_q         <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				B_IDLE: sel_q <= 1'b0;
				B_X2: begin
					fn_q <= 1'b0;
					it_q <= 3'd0;
				end
				B_H3: begin
					fn_q <= ~fn_q;
					if (fn_q) it_q <= it_q + 3'd1;
				end
				B_SC: begin
					sel_q <= 1'b1;
					k_q   <= 3'd0;
				end
				B_PS:    k_q <= (k_q == 3'd3) ? 3'd0 : k_q + 3'd1;
				B_DA:    k_q <= k_q + 3'd1;
				default: k_q <= k_q;
			endcase
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ----- design/mouse_look_view_matrix_unit.sv -----
// Mouse-look view matrix unit. Each input transaction carries one mouse movement
// (delta_x, delta_y, signed Q8.8); both are scaled by look_speed and added to the
// kept yaw (wrapping into [-180,180) degrees) and pitch (clamped to +-89 degrees).
// One output transaction follows per input: right, up and back axes of the
// look-at view matrix in Q2.14 (UNIT_FRAC_BITS) and the three translation terms in
// Q16.16, saturated. Angles reset to zero; look_speed resets to 410, position to 0.
// Configuration is a plain write port (cfg_write, cfg_index, cfg_data) and should
// only be written while the unit is idle. A front end takes the input and updates
// the angles; a two-entry queue hands angle pairs to the back end, which sets the
// sustained rate: one shared 33x33 multiplier runs the sine/cosine series for yaw
// and pitch (five Horner steps each), four axis products and eight position
// products. Output is held in a register until taken.
module mouse_look_view_matrix_unit #(
	parameter int ANGLE_FRAC_BITS = 16,
	parameter int UNIT_FRAC_BITS  = 14
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  mlvm_pkg::in_item_t   in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output mlvm_pkg::out_item_t  out_data,
	input  logic                 cfg_write,
	input  logic [1:0]           cfg_index,
	input  logic [31:0]          cfg_data
);
	import mlvm_pkg::*;

	localparam int QW = 2 * ANGLE_FRAC_BITS + 17;

	logic [15:0]        look_speed_q;
	logic signed [31:0] pos_x_q, pos_y_q, pos_z_q;

	logic          q_push, q_full, q_pop, q_empty;
	logic [QW-1:0] q_wdata, q_rdata;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			look_speed_q <= 16'd410;
			pos_x_q      <= '0;
			pos_y_q      <= '0;
			pos_z_q      <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_LOOK_SPEED: look_speed_q <= cfg_data[15:0];
				CFG_POSITION_X: pos_x_q      <= $signed(cfg_data);
				CFG_POSITION_Y: pos_y_q      <= $signed(cfg_data);
				CFG_POSITION_Z: pos_z_q      <= $signed(cfg_data);
				default: begin
				end
			endcase
		end
	end

	// front: angle update
	mlvm_front #(
		.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.look_speed(look_speed_q),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_data    (q_wdata)
	);

	// angle pairs between front and back
	mlvm_queue #(
		.W(QW)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_data(q_wdata),
		.full     (q_full),
		.pop      (q_pop),
		.pop_data (q_rdata),
		.empty    (q_empty)
	);

	// back: trig, matrix rows and translation
	mlvm_back #(
		.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
		.UNIT_FRAC_BITS (UNIT_FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_pop     (q_pop),
		.q_data    (q_rdata),
		.position_x(pos_x_q),
		.position_y(pos_y_q),
		.position_z(pos_z_q),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
